FILE: rtl/linked_block_chain_allocator_top_defines.svh
// Assertion macros for the linked block chain allocator.
// Included by the top level only; needs nothing else.
`ifndef LINKED_BLOCK_CHAIN_ALLOCATOR_TOP_DEFINES_SVH
`define LINKED_BLOCK_CHAIN_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define LBCA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define LBCA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lbca_pkg.sv
// Shared types, codes and constants of the linked block chain allocator.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps

package lbca_pkg;

  localparam int NUM_BLOCKS_DEF = 64;
  localparam int BLOCKS_RESET   = 64;
  localparam int CNT_W          = 7;
  localparam int IDX_W          = 6;
  localparam int CMD_W          = 2;
  localparam int STS_W          = 2;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK        = 2'd0,
    STS_NO_SPACE  = 2'd1,
    STS_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ALLOC_RD,
    BK_ALLOC_WR,
    BK_FREE_RD,
    BK_FREE_EX,
    BK_READ_RD,
    BK_READ_EX
  } back_state_t;

  // Classified command as it sits in the queue
  typedef struct packed {
    cmd_t             cmd;
    logic [CNT_W-1:0] want;
    logic [IDX_W-1:0] idx;
    logic             bad_idx;
  } item_t;

  // Pool rebuild request from a configuration write
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] pool;
  } rebuild_t;

  // One result transaction
  typedef struct packed {
    logic             strobe;
    status_t          status;
    logic [IDX_W-1:0] index;
    logic             has_link;
    logic [CNT_W-1:0] free_left;
  } result_t;

  // Pool size in use: block count saturated to 1..nb
  function automatic logic [CNT_W-1:0] pool_size(input logic [CNT_W-1:0] bc, input int nb);
    logic [CNT_W-1:0] n;
    n = (bc == '0) ? CNT_W'(1) : bc;
    if (int'(n) > nb) begin
      return CNT_W'(nb);
    end
    return n;
  endfunction

endpackage

FILE: rtl/lbca_front.sv
// Front end: takes command transactions, classifies them and holds the pool size.
// Depends on lbca_pkg.
`timescale 1ns / 1ps

module lbca_front #(
  parameter int NUM_BLOCKS = lbca_pkg::NUM_BLOCKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lbca_pkg::CMD_W-1:0]  in_command,
  input  logic [lbca_pkg::CNT_W-1:0]  in_chunk_count,
  input  logic [lbca_pkg::IDX_W-1:0]  in_block_index,
  input  logic                        cfg_wr_en,
  input  logic [lbca_pkg::CNT_W-1:0]  cfg_wr_data,
  input  logic                        queue_full,
  output logic                        busy,
  output logic                        push,
  output lbca_pkg::item_t             item,
  output logic [lbca_pkg::CNT_W-1:0]  pool,
  output lbca_pkg::rebuild_t          rebuild
);

  localparam int CW = lbca_pkg::CNT_W;
  localparam logic [CW-1:0] POOL_RST =
    lbca_pkg::pool_size(CW'(lbca_pkg::BLOCKS_RESET), NUM_BLOCKS);

  logic [CW-1:0] pool_r;
  logic [CW-1:0] pool_nxt;

  // Pool size register, rewritten by the configuration port
  assign pool_nxt = lbca_pkg::pool_size(cfg_wr_data, NUM_BLOCKS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= POOL_RST;
    end else if (cfg_wr_en) begin
      pool_r <= pool_nxt;
    end
  end

  assign pool          = pool_r;
  assign rebuild.valid = cfg_wr_en;
  assign rebuild.pool  = pool_nxt;

  // Acceptance: stall only when the queue is full
  assign busy = queue_full;
  assign push = start & ~queue_full;

  // Classification: zero chunk count means one block; index range check
  always_comb begin
    item.cmd     = lbca_pkg::cmd_t'(in_command);
    item.want    = (in_chunk_count == '0) ? CW'(1) : in_chunk_count;
    item.idx     = in_block_index;
    item.bad_idx = ({1'b0, in_block_index} >= pool_r);
  end

endmodule

FILE: rtl/lbca_queue.sv
// Short FIFO of classified commands between front and back end.
// Depends on lbca_pkg.
`timescale 1ns / 1ps

module lbca_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lbca_pkg::item_t push_item,
  input  logic            pop,
  output lbca_pkg::item_t head,
  output logic            full,
  output logic            empty
);

  localparam int DEPTH = lbca_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  lbca_pkg::item_t slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]   cnt_r, cnt_nxt;
  logic            push_ok;
  logic            pop_ok;

  assign full    = (cnt_r == NW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push & ~full;
  assign pop_ok  = pop & ~empty;
  assign head    = slot_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Slot storage, no reset needed
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/lbca_back.sv
// Back end: executes allocate, free and read commands over the link memories.
// Depends on lbca_pkg; fed by lbca_queue and lbca_front.
`timescale 1ns / 1ps

module lbca_back #(
  parameter int NUM_BLOCKS = lbca_pkg::NUM_BLOCKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  lbca_pkg::item_t            q_head,
  output logic                       q_pop,
  input  logic [lbca_pkg::CNT_W-1:0] pool,
  input  lbca_pkg::rebuild_t         rebuild,
  output lbca_pkg::result_t          result
);

  localparam int CW = lbca_pkg::CNT_W;
  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int LW = IW + 1;
  localparam int SW = (LW > CW) ? LW : CW;
  localparam logic [LW-1:0] LINK_END = {LW{1'b1}};
  localparam logic [CW-1:0] POOL_RST =
    lbca_pkg::pool_size(CW'(lbca_pkg::BLOCKS_RESET), NUM_BLOCKS);

  function automatic logic in_pool(input logic [LW-1:0] v, input logic [CW-1:0] p);
    return SW'(v) < SW'(p);
  endfunction

  // Control and working registers
  lbca_pkg::back_state_t state_r, state_nxt;
  logic [CW-1:0]     want_r, want_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [LW-1:0]     cur_r, cur_nxt;
  logic              first_r, first_nxt;
  logic [LW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     total_r, total_nxt;
  logic              strobe_r, strobe_nxt;
  lbca_pkg::status_t sts_r, sts_nxt;
  logic [LW-1:0]     res_r, res_nxt;
  logic              link_r, link_nxt;

  // Free list link memory
  logic [LW-1:0]         fl_mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] fl_vld_r;
  logic [LW-1:0]         fl_rd_r;
  logic                  fl_rdv_r;
  logic                  fl_re, fl_we;
  logic [IW-1:0]         fl_ra, fl_wa;
  logic [LW-1:0]         fl_wd;

  // Chain link memory: {in use, next block}
  logic [LW:0]           cl_mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] cl_vld_r;
  logic [LW:0]           cl_rd_r;
  logic                  cl_rdv_r;
  logic                  cl_re, cl_we;
  logic [IW-1:0]         cl_ra, cl_wa;
  logic [LW:0]           cl_wd;

  // Read data seen through the valid bits: unwritten entries give their reset value
  logic [LW-1:0] fl_dflt;
  logic [LW-1:0] fl_data;
  logic          cl_use;
  logic [LW-1:0] cl_link;
  logic          alloc_end;
  logic          no_space;
  logic [IW-1:0] cur_addr;

  assign cur_addr  = cur_r[IW-1:0];
  assign fl_dflt   = in_pool(cur_r + LW'(1), pool) ? cur_r + LW'(1) : LINK_END;
  assign fl_data   = fl_rdv_r ? fl_rd_r : fl_dflt;
  assign cl_use    = cl_rdv_r & cl_rd_r[LW];
  assign cl_link   = cl_rdv_r ? cl_rd_r[LW-1:0] : LINK_END;
  assign alloc_end = (k_r == want_r) || !in_pool(cur_r, pool);
  assign no_space  = (q_head.want > total_r);

  always_ff @(posedge clk) begin
    if (fl_we) begin
      fl_mem[fl_wa] <= fl_wd;
    end
    if (fl_re) begin
      fl_rd_r  <= fl_mem[fl_ra];
      fl_rdv_r <= fl_vld_r[fl_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cl_we) begin
      cl_mem[cl_wa] <= cl_wd;
    end
    if (cl_re) begin
      cl_rd_r  <= cl_mem[cl_ra];
      cl_rdv_r <= cl_vld_r[cl_ra];
    end
  end

  // Valid bits, cleared at once by reset or a pool rebuild
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fl_vld_r <= '0;
      cl_vld_r <= '0;
    end else if (rebuild.valid) begin
      fl_vld_r <= '0;
      cl_vld_r <= '0;
    end else begin
      if (fl_we) begin
        fl_vld_r[fl_wa] <= 1'b1;
      end
      if (cl_we) begin
        cl_vld_r[cl_wa] <= 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lbca_pkg::BK_IDLE: begin
        if (!q_empty) begin
          unique case (q_head.cmd)
            lbca_pkg::CMD_ALLOC: state_nxt = no_space ? lbca_pkg::BK_IDLE
                                                      : lbca_pkg::BK_ALLOC_RD;
            lbca_pkg::CMD_FREE:  state_nxt = q_head.bad_idx ? lbca_pkg::BK_IDLE
                                                            : lbca_pkg::BK_FREE_RD;
            lbca_pkg::CMD_READ:  state_nxt = q_head.bad_idx ? lbca_pkg::BK_IDLE
                                                            : lbca_pkg::BK_READ_RD;
            lbca_pkg::CMD_NOP:   state_nxt = lbca_pkg::BK_IDLE;
          endcase
        end
      end
      lbca_pkg::BK_ALLOC_RD: begin
        state_nxt = alloc_end ? lbca_pkg::BK_IDLE : lbca_pkg::BK_ALLOC_WR;
      end
      lbca_pkg::BK_ALLOC_WR: state_nxt = lbca_pkg::BK_ALLOC_RD;
      lbca_pkg::BK_FREE_RD:  state_nxt = lbca_pkg::BK_FREE_EX;
      lbca_pkg::BK_FREE_EX: begin
        if (!cl_use || !in_pool(cl_link, pool)) begin
          state_nxt = lbca_pkg::BK_IDLE;
        end else begin
          state_nxt = lbca_pkg::BK_FREE_RD;
        end
      end
      lbca_pkg::BK_READ_RD:  state_nxt = lbca_pkg::BK_READ_EX;
      lbca_pkg::BK_READ_EX:  state_nxt = lbca_pkg::BK_IDLE;
      default:               state_nxt = lbca_pkg::BK_IDLE;
    endcase
  end

  // Outputs: memory control and datapath updates
  always_comb begin
    q_pop      = 1'b0;
    fl_re      = 1'b0;
    fl_ra      = cur_addr;
    fl_we      = 1'b0;
    fl_wa      = cur_addr;
    fl_wd      = LINK_END;
    cl_re      = 1'b0;
    cl_ra      = cur_addr;
    cl_we      = 1'b0;
    cl_wa      = cur_addr;
    cl_wd      = {1'b0, LINK_END};
    want_nxt   = want_r;
    k_nxt      = k_r;
    cur_nxt    = cur_r;
    first_nxt  = first_r;
    head_nxt   = head_r;
    total_nxt  = total_r;
    strobe_nxt = 1'b0;
    sts_nxt    = sts_r;
    res_nxt    = res_r;
    link_nxt   = link_r;

    unique case (state_r)
      lbca_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          res_nxt  = '0;
          link_nxt = 1'b0;
          sts_nxt  = lbca_pkg::STS_OK;
          unique case (q_head.cmd)
            lbca_pkg::CMD_ALLOC: begin
              if (no_space) begin
                strobe_nxt = 1'b1;
                sts_nxt    = lbca_pkg::STS_NO_SPACE;
              end else begin
                want_nxt = q_head.want;
                k_nxt    = '0;
                cur_nxt  = head_r;
                res_nxt  = head_r;
              end
            end
            lbca_pkg::CMD_FREE, lbca_pkg::CMD_READ: begin
              if (q_head.bad_idx) begin
                strobe_nxt = 1'b1;
                sts_nxt    = lbca_pkg::STS_BAD_INDEX;
              end else begin
                cur_nxt   = LW'(q_head.idx);
                first_nxt = 1'b1;
              end
            end
            lbca_pkg::CMD_NOP: strobe_nxt = 1'b1;
          endcase
        end
      end

      // Allocate: fetch the free link of the current head block
      lbca_pkg::BK_ALLOC_RD: begin
        if (alloc_end) begin
          strobe_nxt = 1'b1;
        end else begin
          fl_re = 1'b1;
        end
      end

      // Allocate: unlink the block and chain it to the next one
      lbca_pkg::BK_ALLOC_WR: begin
        fl_we     = 1'b1;
        fl_wd     = LINK_END;
        cl_we     = 1'b1;
        cl_wd     = {1'b1, ((k_r + CW'(1)) < want_r) ? fl_data : LINK_END};
        total_nxt = total_r - CW'(1);
        cur_nxt   = fl_data;
        head_nxt  = fl_data;
        k_nxt     = k_r + CW'(1);
      end

      lbca_pkg::BK_FREE_RD: cl_re = 1'b1;

      // Free: push an in-use block on the free list and follow its chain link; stop at a block not in use
      lbca_pkg::BK_FREE_EX: begin
        if (!cl_use) begin
          strobe_nxt = 1'b1;
          sts_nxt    = first_r ? lbca_pkg::STS_BAD_INDEX : lbca_pkg::STS_OK;
        end else begin
          fl_we     = 1'b1;
          fl_wd     = head_r;
          cl_we     = 1'b1;
          cl_wd     = {1'b0, LINK_END};
          head_nxt  = cur_r;
          total_nxt = total_r + CW'(1);
          first_nxt = 1'b0;
          cur_nxt   = cl_link;
          if (!in_pool(cl_link, pool)) begin
            strobe_nxt = 1'b1;
          end
        end
      end

      lbca_pkg::BK_READ_RD: cl_re = 1'b1;

      lbca_pkg::BK_READ_EX: begin
        strobe_nxt = 1'b1;
        if (in_pool(cl_link, pool)) begin
          res_nxt  = cl_link;
          link_nxt = 1'b1;
        end
      end

      default: begin
      end
    endcase

    // A configuration write rebuilds the free list
    if (rebuild.valid) begin
      head_nxt  = '0;
      total_nxt = rebuild.pool;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lbca_pkg::BK_IDLE;
      strobe_r <= 1'b0;
      head_r   <= '0;
      total_r  <= POOL_RST;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      head_r   <= head_nxt;
      total_r  <= total_nxt;
    end
  end

  // Working and result payload registers
  always_ff @(posedge clk) begin
    want_r  <= want_nxt;
    k_r     <= k_nxt;
    cur_r   <= cur_nxt;
    first_r <= first_nxt;
    sts_r   <= sts_nxt;
    res_r   <= res_nxt;
    link_r  <= link_nxt;
  end

  assign result.strobe    = strobe_r;
  assign result.status    = sts_r;
  assign result.index     = lbca_pkg::IDX_W'(res_r);
  assign result.has_link  = link_r;
  assign result.free_left = total_r;

endmodule

FILE: rtl/linked_block_chain_allocator_top.sv
// Sequence: rejected and no-op commands are answered straight from idle; a read fetches the
// chain link, then answers; an allocate walks the free list and a free walks the chain, block
// by block, the free stopping at a block not in use or at the chain end. Throughput: one
// command at a time in the back end, set by the read-then-write of one link memory port per
// block. Two commands queue. Reset: synchronous, active low; clears control state and the
// link valid bits at once, no clearing pass. Results cannot be stalled.
`timescale 1ns / 1ps
`include "linked_block_chain_allocator_top_defines.svh"

module linked_block_chain_allocator_top #(
  parameter int NUM_BLOCKS = lbca_pkg::NUM_BLOCKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [lbca_pkg::CMD_W-1:0] in_command,
  input  logic [lbca_pkg::CNT_W-1:0] in_chunk_count,
  input  logic [lbca_pkg::IDX_W-1:0] in_block_index,
  input  logic                       cfg_wr_en,
  input  logic [lbca_pkg::CNT_W-1:0] cfg_wr_data,
  output logic                       out_strobe,
  output logic [lbca_pkg::STS_W-1:0] out_status,
  output logic [lbca_pkg::IDX_W-1:0] out_result_index,
  output logic                       out_has_link,
  output logic [lbca_pkg::CNT_W-1:0] out_free_left
);

  logic                       push;
  lbca_pkg::item_t            push_item;
  lbca_pkg::item_t            q_head;
  logic                       q_full;
  logic                       q_empty;
  logic                       q_pop;
  logic [lbca_pkg::CNT_W-1:0] pool;
  lbca_pkg::rebuild_t         rebuild;
  lbca_pkg::result_t          result;

  lbca_front #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_command     (in_command),
    .in_chunk_count (in_chunk_count),
    .in_block_index (in_block_index),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .queue_full     (q_full),
    .busy           (busy),
    .push           (push),
    .item           (push_item),
    .pool           (pool),
    .rebuild        (rebuild)
  );

  lbca_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  lbca_back #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .pool    (pool),
    .rebuild (rebuild),
    .result  (result)
  );

  // Result transaction ports
  assign out_strobe       = result.strobe;
  assign out_status       = result.status;
  assign out_result_index = result.index;
  assign out_has_link     = result.has_link;
  assign out_free_left    = result.free_left;

  // Checks
  `LBCA_ASSERT_IMP(a_link_ok_in_pool, clk, rst_n, out_strobe && out_has_link && !$past(cfg_wr_en), out_status == lbca_pkg::STS_OK && out_result_index < pool, "read link result outside pool or not ok")
  `LBCA_ASSERT_IMP(a_no_space_keeps_count, clk, rst_n, out_strobe && out_status == lbca_pkg::STS_NO_SPACE && !$past(cfg_wr_en), $stable(out_free_left), "rejected allocate changed the free count")
  `LBCA_ASSERT_NXT(a_rebuild_refills, clk, rst_n, cfg_wr_en, out_free_left == pool, "pool rebuild did not refill the free count")

endmodule
